// ===== rtl/bsr_pkg.sv =====
package bsr_pkg;

  localparam int TRACK_TABLE_DEPTH = 64;
  localparam int SECTOR_TABLE_DEPTH = 64;
  localparam int TT_AW = $clog2(TRACK_TABLE_DEPTH);
  localparam int ST_AW = $clog2(SECTOR_TABLE_DEPTH);
  localparam int ADDR_W = 24;
  localparam logic [6:0] RUN_MAX = 7'd64;

  localparam logic [2:0] REG_SPT = 3'd0;
  localparam logic [2:0] REG_HEADS = 3'd1;
  localparam logic [2:0] REG_REMAP = 3'd2;
  localparam logic [2:0] REG_TCOUNT = 3'd3;
  localparam logic [2:0] REG_SCOUNT = 3'd4;
  localparam logic [2:0] REG_TBASE = 3'd5;
  localparam logic [2:0] REG_SBASE = 3'd6;

  localparam logic [1:0] OP_WR_TRACK = 2'd0;
  localparam logic [1:0] OP_WR_SECTOR = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  table_index;
    logic [23:0] value;
    logic        request_end;
  } bsr_in_t;

  typedef struct packed {
    logic [23:0] cylinder;
    logic [7:0]  head;
    logic [5:0]  start_sector;
    logic [6:0]  sector_count;
    logic        final_command;
  } bsr_out_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  table_index;
    logic [23:0] value;
    logic        request_end;
  } bsr_job_t;

  typedef struct packed {
    logic [5:0]  spt;
    logic [8:0]  heads;
    logic        remap;
    logic [6:0]  tcount;
    logic [6:0]  scount;
    logic [23:0] tbase;
    logic [23:0] sbase;
  } bsr_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TDIV, ST_TSRCH, ST_TMUL, ST_SSRCH, ST_CDIV, ST_HDIV,
    ST_EMIT1, ST_EMIT2
  } bsr_state_t;

endpackage

// ===== rtl/bad_sector_remap_chs_runs_core.sv =====
// Translates logical sectors to cylinder, head and sector, remapping through bad-track
// and bad-sector tables when enabled, and merges sectors on one track into read commands.
// Every transaction passes a two-entry queue in order; the translation engine takes one
// from it per cycle when idle. A table write or an unknown operation stays in idle.
// A translate loads its sector, divides it by sectors per cylinder for the cylinder, then
// by sectors per track for head and sector, and hands out its commands once the output
// buffer is empty. Remapping first adds a track division and a bad-track search over the
// valid entries, then a remap step on a hit, else a bad-sector search. Configuration
// must be written only while nothing is in flight; the block itself does not enforce this.
module bad_sector_remap_chs_runs_core import bsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  bsr_in_t     in_data,
  output logic        out_empty,
  input  logic        out_pop,
  output bsr_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  bsr_cfg_t cfg_r;
  logic job_valid, job_take;
  bsr_job_t job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{spt: 6'd63, heads: 9'd16, remap: 1'b0, tcount: '0, scount: '0,
                 tbase: '0, sbase: '0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPT:    cfg_r.spt <= cfg_data[5:0];
        REG_HEADS:  cfg_r.heads <= cfg_data[8:0];
        REG_REMAP:  cfg_r.remap <= cfg_data[0];
        REG_TCOUNT: cfg_r.tcount <= cfg_data[6:0];
        REG_SCOUNT: cfg_r.scount <= cfg_data[6:0];
        REG_TBASE:  cfg_r.tbase <= cfg_data;
        REG_SBASE:  cfg_r.sbase <= cfg_data;
        default: ;
      endcase
    end
  end

  bsr_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .job_valid, .job, .job_take
  );

  bsr_back u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .job_valid, .job, .job_take, .out_empty, .out_pop, .out_data
  );

endmodule

// ===== rtl/bsr_front.sv =====
module bsr_front import bsr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  bsr_in_t  in_data,
  output logic     job_valid,
  output bsr_job_t job,
  input  logic     job_take
);

  localparam int QD = 2;
  bsr_job_t q_r [QD];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic acc, push_job;

  assign in_full = (cnt_r == 2'(QD));
  assign acc = in_push && !in_full;
  assign push_job = acc;
  assign job_valid = cnt_r != 2'd0;
  assign job = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_job) begin
      q_r[wp_r] <= '{operation: in_data.operation, table_index: in_data.table_index,
                     value: in_data.value, request_end: in_data.request_end};
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push_job) wp_r <= wp_r + 1'b1;
      if (job_take && job_valid) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push_job) - 2'(job_take && job_valid);
    end
  end

endmodule

// ===== rtl/bsr_back.sv =====
module bsr_back import bsr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  bsr_cfg_t cfg,
  input  logic     job_valid,
  input  bsr_job_t job,
  output logic     job_take,
  output logic     out_empty,
  input  logic     out_pop,
  output bsr_out_t out_data
);

  bsr_state_t state_r, state_nxt;
  logic [23:0] tt_mem [TRACK_TABLE_DEPTH];
  logic [23:0] st_mem [SECTOR_TABLE_DEPTH];
  logic [23:0] tt_q_r, st_q_r;
  logic [7:0]  i_r;
  logic        rd_ok_r;

  logic [23:0] lsec_r, phys_r, quo_r, rem_r, dvd_r;
  logic [23:0] trk_r;
  logic [5:0]  off_r;
  logic [4:0]  bit_r;
  logic [14:0] dsr_r;
  logic        end_r;
  logic [23:0] cyl_r;
  logic [7:0]  hd_r;
  logic [5:0]  sec_r;

  logic [23:0] run_cyl_r;
  logic [7:0]  run_head_r;
  logic [5:0]  run_start_r;
  logic [6:0]  run_len_r;

  bsr_out_t ob_r [2];
  logic ow_r, or_r;
  logic [1:0] ocnt_r;

  logic [5:0]  spt;
  logic [8:0]  hds;
  logic [14:0] spc;
  logic [7:0]  tn, sn;
  logic [24:0] trial;
  logic        div_last;
  logic        brk;
  logic        push1, push2;
  logic        tt_we, st_we;
  bsr_out_t    ob1, ob2;

  assign spt = cfg.spt == 6'd0 ? 6'd1 : cfg.spt;
  assign hds = cfg.heads == 9'd0 ? 9'd1 : (cfg.heads > 9'd256 ? 9'd256 : cfg.heads);
  assign spc = 15'(spt) * 15'(hds);
  assign tn = 32'(cfg.tcount) < TRACK_TABLE_DEPTH ? 8'(cfg.tcount) : 8'(TRACK_TABLE_DEPTH);
  assign sn = 32'(cfg.scount) < SECTOR_TABLE_DEPTH ? 8'(cfg.scount) : 8'(SECTOR_TABLE_DEPTH);
  assign trial = {rem_r, dvd_r[23]} - {10'd0, dsr_r};
  assign div_last = bit_r == 5'd0;
  assign brk = run_len_r != 7'd0 && (cyl_r != run_cyl_r || hd_r != run_head_r);
  assign tt_we = state_r == ST_IDLE && job_valid && job.operation == OP_WR_TRACK
                 && 32'(job.table_index) < TRACK_TABLE_DEPTH;
  assign st_we = state_r == ST_IDLE && job_valid && job.operation == OP_WR_SECTOR
                 && 32'(job.table_index) < SECTOR_TABLE_DEPTH;

  assign out_empty = ocnt_r == 2'd0;
  assign out_data = ob_r[or_r];

  always_ff @(posedge clk) begin
    if (tt_we) tt_mem[job.table_index[TT_AW-1:0]] <= job.value;
    if (st_we) st_mem[job.table_index[ST_AW-1:0]] <= job.value;
    tt_q_r <= tt_mem[i_r[TT_AW-1:0]];
    st_q_r <= st_mem[i_r[ST_AW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid && job.operation == OP_TRANSLATE) begin
          state_nxt = cfg.remap ? ST_TDIV : ST_CDIV;
        end
      end
      ST_TDIV:  if (div_last) state_nxt = ST_TSRCH;
      ST_TSRCH: begin
        if (rd_ok_r && tt_q_r == trk_r) state_nxt = ST_TMUL;
        else if (i_r >= tn) state_nxt = ST_SSRCH;
      end
      ST_TMUL:  state_nxt = ST_CDIV;
      ST_SSRCH: begin
        if ((rd_ok_r && st_q_r == lsec_r) || i_r >= sn) state_nxt = ST_CDIV;
      end
      ST_CDIV:  if (div_last) state_nxt = ST_HDIV;
      ST_HDIV:  if (div_last) state_nxt = ST_EMIT1;
      ST_EMIT1: if (ocnt_r == 2'd0) state_nxt = ST_EMIT2;
      ST_EMIT2: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    job_take = state_r == ST_IDLE && job_valid;
    push1 = state_r == ST_EMIT2 && brk;
    push2 = state_r == ST_EMIT2 && end_r;
    ob1 = '{cylinder: run_cyl_r, head: run_head_r, start_sector: run_start_r,
            sector_count: run_len_r, final_command: 1'b0};
    ob2 = '{cylinder: cyl_r, head: hd_r,
            start_sector: brk || run_len_r == 7'd0 ? sec_r : run_start_r,
            sector_count: brk || run_len_r == 7'd0 ? 7'd1 :
                          (run_len_r < RUN_MAX ? run_len_r + 7'd1 : run_len_r),
            final_command: 1'b1};
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        lsec_r <= job.value;
        end_r <= job.request_end;
        phys_r <= job.value;
        dvd_r <= job.value;
        rem_r <= '0;
        bit_r <= 5'd23;
        i_r <= '0;
        rd_ok_r <= 1'b0;
        dsr_r <= cfg.remap ? 15'(spt) : spc;
      end
      ST_TDIV: begin
        dvd_r <= {dvd_r[22:0], ~trial[24]};
        rem_r <= trial[24] ? {rem_r[22:0], dvd_r[23]} : trial[23:0];
        bit_r <= bit_r - 5'd1;
        if (div_last) begin
          trk_r <= {dvd_r[22:0], ~trial[24]};
          off_r <= trial[24] ? 6'({rem_r[22:0], dvd_r[23]}) : 6'(trial);
          i_r <= '0;
          rd_ok_r <= 1'b0;
        end
      end
      ST_TSRCH: begin
        if (rd_ok_r && tt_q_r == trk_r) begin
          phys_r <= 24'(15'(i_r - 8'd1) * 15'(spt));
        end else if (i_r >= tn) begin
          i_r <= '0;
          rd_ok_r <= 1'b0;
        end else begin
          i_r <= i_r + 8'd1;
          rd_ok_r <= 1'b1;
        end
      end
      ST_TMUL: begin
        phys_r <= cfg.tbase + phys_r + 24'(off_r);
      end
      ST_SSRCH: begin
        if (rd_ok_r && st_q_r == lsec_r) begin
          phys_r <= cfg.sbase + 24'(i_r - 8'd1);
        end else if (i_r < sn) begin
          i_r <= i_r + 8'd1;
          rd_ok_r <= 1'b1;
        end
      end
      default: ;
    endcase
    if (state_nxt == ST_CDIV && state_r != ST_CDIV && state_r != ST_IDLE) begin
      dvd_r <= (state_r == ST_SSRCH && rd_ok_r && st_q_r == lsec_r)
               ? cfg.sbase + 24'(i_r - 8'd1)
               : (state_r == ST_TMUL ? cfg.tbase + phys_r + 24'(off_r) : phys_r);
      rem_r <= '0;
      bit_r <= 5'd23;
      dsr_r <= spc;
    end
    if (state_r == ST_CDIV) begin
      if (div_last) begin
        cyl_r <= {dvd_r[22:0], ~trial[24]};
        dvd_r <= trial[24] ? {rem_r[22:0], dvd_r[23]} : trial[23:0];
        rem_r <= '0;
        bit_r <= 5'd23;
        dsr_r <= 15'(spt);
      end else begin
        dvd_r <= {dvd_r[22:0], ~trial[24]};
        rem_r <= trial[24] ? {rem_r[22:0], dvd_r[23]} : trial[23:0];
        bit_r <= bit_r - 5'd1;
      end
    end
    if (state_r == ST_HDIV) begin
      dvd_r <= {dvd_r[22:0], ~trial[24]};
      rem_r <= trial[24] ? {rem_r[22:0], dvd_r[23]} : trial[23:0];
      bit_r <= bit_r - 5'd1;
      if (div_last) begin
        hd_r <= 8'({dvd_r[22:0], ~trial[24]});
        sec_r <= trial[24] ? 6'({rem_r[22:0], dvd_r[23]}) : 6'(trial);
      end
    end
    if (push1) ob_r[ow_r] <= ob1;
    if (push2) ob_r[push1 ? ~ow_r : ow_r] <= ob2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      run_cyl_r <= '0;
      run_head_r <= '0;
      run_start_r <= '0;
      run_len_r <= '0;
      ow_r <= 1'b0;
      or_r <= 1'b0;
      ocnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EMIT2) begin
        if (end_r) begin
          run_len_r <= '0;
        end else if (brk || run_len_r == 7'd0) begin
          run_cyl_r <= cyl_r;
          run_head_r <= hd_r;
          run_start_r <= sec_r;
          run_len_r <= 7'd1;
        end else if (run_len_r < RUN_MAX) begin
          run_len_r <= run_len_r + 7'd1;
        end
      end
      ow_r <= ow_r ^ push1 ^ push2;
      if (out_pop && !out_empty) or_r <= ~or_r;
      ocnt_r <= ocnt_r + 2'(push1) + 2'(push2) - 2'(out_pop && !out_empty);
    end
  end

endmodule
